// File: rtl/skts_pkg.sv
// Shared types, constants and codes for the sorted key table search block.
`timescale 1ns / 1ps
`default_nettype none

package skts_pkg;

    localparam int TABLE_DEPTH  = 4096;
    localparam int KEY_BITS     = 17;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = IDX_W + 1;
    localparam int ENTRY_IDX_W  = 12;

    localparam logic [KEY_BITS-1:0] RESERVED_KEY = KEY_BITS'(99999);

    typedef enum logic {
        REQ_APPEND = 1'b0,
        REQ_LOOKUP = 1'b1
    } t_req_type;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_ORDER     = 3'd2,
        ST_FULL      = 3'd3,
        ST_RESERVED  = 3'd4
    } t_status;

    typedef struct packed {
        t_req_type           req_type;
        logic [KEY_BITS-1:0] key_value;
    } t_req;

    typedef struct packed {
        logic                   found;
        logic [ENTRY_IDX_W-1:0] entry_index;
        t_status                status;
    } t_rsp;

    typedef struct packed {
        logic                start;
        logic [KEY_BITS-1:0] key;
        logic [CNT_W-1:0]    count;
    } t_srch_ctl;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] index;
    } t_srch_res;

endpackage

`default_nettype wire

// File: rtl/skts_search.sv
// Binary search sequencer: one probe of the key memory per cycle.
`timescale 1ns / 1ps
`default_nettype none

module skts_search import skts_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_srch_ctl           i_ctl,
    input  wire logic [KEY_BITS-1:0] i_rd_data,
    output logic      [IDX_W-1:0]    o_rd_addr,
    output t_srch_res                o_res
);

    typedef enum logic {
        S_IDLE,
        S_CMP
    } t_state;

    t_state              r_state;
    logic [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hi;
    logic [IDX_W-1:0]    r_mid;
    t_srch_res           r_res;

    logic                n_eq;
    logic                n_less;
    logic [CNT_W-1:0]    n_lo;
    logic [CNT_W-1:0]    n_hi;
    logic [CNT_W-1:0]    n_mid;
    logic [CNT_W-1:0]    n_mid0;

    always_comb begin
        n_eq   = (i_rd_data == r_key);
        n_less = (r_key < i_rd_data);
        n_lo   = n_less ? r_lo : ({1'b0, r_mid} + CNT_W'(1));
        n_hi   = n_less ? {1'b0, r_mid} : r_hi;
        n_mid  = n_lo + ((n_hi - n_lo) >> 1);
        n_mid0 = i_ctl.count >> 1;
        if (r_state == S_CMP) begin
            o_rd_addr = n_mid[IDX_W-1:0];
        end else begin
            o_rd_addr = n_mid0[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_res.done <= 1'b0;
        end else begin
            r_res.done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_key   <= i_ctl.key;
                        r_lo    <= '0;
                        r_hi    <= i_ctl.count;
                        r_mid   <= n_mid0[IDX_W-1:0];
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (n_eq) begin
                        r_res.done  <= 1'b1;
                        r_res.found <= 1'b1;
                        r_res.index <= r_mid;
                        r_state     <= S_IDLE;
                    end else if (n_lo < n_hi) begin
                        r_lo  <= n_lo;
                        r_hi  <= n_hi;
                        r_mid <= n_mid[IDX_W-1:0];
                    end else begin
                        r_res.done  <= 1'b1;
                        r_res.found <= 1'b0;
                        r_res.index <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// File: rtl/sorted_key_table_search_core.sv
// Top level of the sorted key table: appends and binary-search lookups.
//
// Request channel i_req_valid / o_req_stall carries one item: an append or a
// lookup of key_value. Response channel o_rsp_valid / i_rsp_stall returns one
// item for each request, in order.
// An append is checked and written in the accept cycle; its response goes
// to the pending register and then the output register. A lookup probes the
// key memory once a cycle, comparing each registered read before the next
// probe: up to log2(TABLE_DEPTH) + 1 probes (13 at 4096 entries). A lookup
// in an empty table skips the search and is answered at once, like an append.
// One request is worked on at a time; the next is taken once the previous
// response has left the block or sits in the output register.
// While i_rsp_stall is high the response holds in the output register and
// one further finished response waits behind it; requests then stall.
// Reset empties the table: entry count and last key clear, no memory sweep
// is needed since only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table_search_core import skts_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_stall,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_stall,
    output t_rsp      o_rsp
);

    typedef enum logic {
        IDLE,
        SEARCH
    } t_state;

    t_state              r_state;
    logic [KEY_BITS-1:0] r_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0] r_rd_data;
    logic [CNT_W-1:0]    r_count;
    logic [KEY_BITS-1:0] r_last_key;
    logic                r_empty;
    logic                r_pend;
    t_rsp                r_pend_rsp;
    logic                r_rsp_valid;
    t_rsp                r_rsp;

    logic                n_accept;
    logic                n_load;
    logic                n_order_err;
    logic                n_reserved;
    logic                n_full;
    logic                n_write;
    t_srch_ctl           n_ctl;
    t_srch_res           n_res;
    logic [IDX_W-1:0]    n_rd_addr;

    assign o_req_stall = (r_state != IDLE) || r_pend;
    assign n_accept    = i_req_valid && !o_req_stall;
    assign n_load      = r_pend && (!r_rsp_valid || !i_rsp_stall);

    always_comb begin
        n_order_err = !r_empty && (i_req.key_value <= r_last_key);
        n_reserved  = (i_req.key_value >= RESERVED_KEY);
        n_full      = (r_count >= CNT_W'(TABLE_DEPTH));
        n_write     = n_accept && (i_req.req_type == REQ_APPEND) &&
                      !n_order_err && !n_reserved && !n_full;
        n_ctl.start = n_accept && (i_req.req_type == REQ_LOOKUP) && (r_count != '0);
        n_ctl.key   = i_req.key_value;
        n_ctl.count = r_count;
    end

    skts_search u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (n_ctl),
        .i_rd_data (r_rd_data),
        .o_rd_addr (n_rd_addr),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (n_write) begin
            r_mem[r_count[IDX_W-1:0]] <= i_req.key_value;
        end
        r_rd_data <= r_mem[n_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= IDLE;
            r_count     <= '0;
            r_last_key  <= '0;
            r_empty     <= 1'b1;
            r_pend      <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (n_load) begin
                r_rsp       <= r_pend_rsp;
                r_rsp_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end

            unique case (r_state)
                IDLE: begin
                    if (n_accept) begin
                        r_pend_rsp.found       <= 1'b0;
                        r_pend_rsp.entry_index <= '0;
                        if (i_req.req_type == REQ_LOOKUP) begin
                            r_pend_rsp.status <= ST_NOT_FOUND;
                            if (r_count != '0) begin
                                r_state <= SEARCH;
                            end else begin
                                r_pend <= 1'b1;
                            end
                        end else begin
                            r_pend <= 1'b1;
                            if (n_order_err) begin
                                r_pend_rsp.status <= ST_ORDER;
                            end else if (n_reserved) begin
                                r_pend_rsp.status <= ST_RESERVED;
                            end else if (n_full) begin
                                r_pend_rsp.status <= ST_FULL;
                            end else begin
                                r_pend_rsp.status      <= ST_OK;
                                r_pend_rsp.entry_index <= ENTRY_IDX_W'(r_count);
                                r_count                <= r_count + CNT_W'(1);
                                r_last_key             <= i_req.key_value;
                                r_empty                <= 1'b0;
                            end
                        end
                    end
                end
                SEARCH: begin
                    if (n_res.done) begin
                        r_pend                 <= 1'b1;
                        r_pend_rsp.found       <= n_res.found;
                        r_pend_rsp.entry_index <= ENTRY_IDX_W'(n_res.index);
                        r_pend_rsp.status      <= n_res.found ? ST_OK : ST_NOT_FOUND;
                        r_state                <= IDLE;
                    end
                end
                default: r_state <= IDLE;
            endcase
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire
